@@ rtl/duplicate_point_filter_assert.svh @@
// Assertion macros for the duplicate point filter checker.
// Used by dpf_checker; no other dependencies.
`ifndef DUPLICATE_POINT_FILTER_ASSERT_SVH
`define DUPLICATE_POINT_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpf check failed");

// Next-cycle implication, disabled while in reset.
`define DPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpf check failed");

`endif

@@ rtl/dpf_pkg.sv @@
// Shared types and constants for the duplicate point filter.
// No dependencies.
`default_nettype none

package dpf_pkg;

  localparam int MaxPoints  = 256;
  localparam int CoordBits  = 22;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int CntW       = IdxW + 1;
  localparam int PointIdxW  = 8;
  localparam int EntryW     = 2 * CoordBits;

  typedef struct packed {
    logic [CoordBits-1:0] x_pos;
    logic [CoordBits-1:0] y_pos;
    logic                 last_point;
  } in_t;

  typedef struct packed {
    logic [PointIdxW-1:0] point_index;
    logic                 keep;
    logic                 image_end;
    logic                 overflow;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [IdxW-1:0]   waddr;
    logic [EntryW-1:0] wdata;
    logic              re;
    logic [IdxW-1:0]   raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush,
    StEmit
  } state_e;

endpackage

`default_nettype wire

@@ rtl/duplicate_point_filter.sv @@
// Duplicate point filter. With cnt points already stored for the image, a
// point is compared against each of them in turn, written to the store
// unless it overflows, and its result is loaded into the output register;
// the first point of an image and an overflow point skip the scan. A
// stalled result beat holds the next point back from the output register.
// One comparator checks one stored entry per cycle through the store's
// single read port. The input is ready only while the sequencer is idle. The
// result sits in an output register, so the next point is taken while a
// result still waits. There is no clearing pass after reset.
// Depends on dpf_pkg, dpf_store and dpf_ctrl.
`default_nettype none

module duplicate_point_filter
  import dpf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  mem_req_t          mem_req;
  logic [EntryW-1:0] mem_rdata;
  logic              out_free;
  logic              emit;
  out_t              result;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q;

  assign out_free = !out_valid_q || out_ready_i;

  dpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .result_o    (result),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  dpf_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output beat register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/dpf_store.sv @@
// Point store: one write port, one read port with registered read data.
// Depends on dpf_pkg.
`default_nettype none

module dpf_store
  import dpf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire mem_req_t          req_i,
  output logic     [EntryW-1:0]  rdata_o
);

  logic [EntryW-1:0] mem_q [MaxPoints];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/dpf_ctrl.sv @@
// Sequencer: walks the store with one shared comparator, then writes the
// new point and produces the result. Depends on dpf_pkg.
`default_nettype none

module dpf_ctrl
  import dpf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire in_t               in_data_i,
  output logic                   in_ready_o,
  input  wire logic              out_free_i,
  output logic                   emit_o,
  output out_t                   result_o,
  output mem_req_t               mem_req_o,
  input  wire logic [EntryW-1:0] mem_rdata_i
);

  localparam logic [CntW-1:0]      CntFull = CntW'(MaxPoints);
  localparam logic [PointIdxW-1:0] IdxSat  = PointIdxW'(MaxPoints - 1);

  state_e            state_q, state_d;
  logic [EntryW-1:0] coord_q, coord_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   addr_q, addr_d;
  logic              seen_q, seen_d;
  logic              ovf_q, ovf_d;
  logic              rd_pend_q, rd_pend_d;
  logic              accept;
  logic              hit;
  logic [CntW-1:0]   addr_inc;

  assign accept   = in_valid_i && in_ready_o;
  assign addr_inc = addr_q + CntW'(1);
  // The one comparator: data from the read issued last cycle.
  assign hit      = rd_pend_q && (mem_rdata_i == coord_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cnt_q == CntFull || cnt_q == '0) begin
            state_d = StEmit;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (addr_inc == cnt_q) begin
          state_d = StFlush;
        end
      end
      StFlush: state_d = StEmit;
      StEmit: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    coord_d    = coord_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    addr_d     = addr_q;
    seen_d     = seen_q || hit;
    ovf_d      = ovf_q;
    rd_pend_d  = 1'b0;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    mem_req_o  = '0;
    mem_req_o.raddr = addr_q[IdxW-1:0];
    mem_req_o.waddr = cnt_q[IdxW-1:0];
    mem_req_o.wdata = coord_q;
    result_o.point_index = ovf_q ? IdxSat : PointIdxW'(cnt_q);
    result_o.keep        = !ovf_q && !seen_q;
    result_o.image_end   = last_q;
    result_o.overflow    = ovf_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (accept) begin
          coord_d = {in_data_i.x_pos, in_data_i.y_pos};
          last_d  = in_data_i.last_point;
          ovf_d   = (cnt_q == CntFull);
          seen_d  = 1'b0;
          addr_d  = '0;
        end
      end
      StScan: begin
        mem_req_o.re = 1'b1;
        rd_pend_d    = 1'b1;
        addr_d       = addr_inc;
      end
      StFlush: begin
      end
      StEmit: begin
        if (out_free_i) begin
          emit_o       = 1'b1;
          mem_req_o.we = !ovf_q;
          if (last_q) begin
            cnt_d = '0;
          end else if (!ovf_q) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    last_q  <= last_d;
    addr_q  <= addr_d;
    seen_q  <= seen_d;
    ovf_q   <= ovf_d;
  end

endmodule

`default_nettype wire

@@ rtl/dpf_checker.sv @@
// Port-level checks for the duplicate point filter, bound to the top level.
// Depends on dpf_pkg and duplicate_point_filter_assert.svh.
`default_nettype none

`include "duplicate_point_filter_assert.svh"

module dpf_checker
  import dpf_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  localparam logic [PointIdxW-1:0] IdxSat = PointIdxW'(MaxPoints - 1);

  // a stalled result beat holds
  `DPF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
  // an overflow point is never kept and reports the saturated index
  `DPF_ASSERT_NOW(a_ovf_no_keep, clk_i, rst_ni, out_valid_o && out_data_o.overflow,
    !out_data_o.keep && out_data_o.point_index == IdxSat)
  // one point in flight: busy right after an input beat
  `DPF_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // no result beat in the cycle right after an input beat taken while no result waits
  `DPF_ASSERT_NEXT(a_no_instant_out, clk_i, rst_ni,
    in_valid_i && in_ready_o && !out_valid_o, !out_valid_o)

endmodule

bind duplicate_point_filter dpf_checker u_dpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ tb/sv/dpf_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the duplicate point filter testbench: predicts index, keep,
// image end and overflow per point and checks the result beats. Depends on dpf_pkg.

package dpf_tb_pkg;
  import dpf_pkg::*;

  class dedup_scoreboard;
    logic [CoordBits-1:0] kept_x [MaxPoints];
    logic [CoordBits-1:0] kept_y [MaxPoints];
    int unsigned          image_fill;
    out_t                 expected_q [$];
    int unsigned          errors;

    function new();
      image_fill = 0;
      errors     = 0;
    endfunction

    // Called for every accepted input beat.
    function void note_point(in_t p);
      out_t        want;
      bit          dup;
      int unsigned i;
      want = '0;
      dup  = 1'b0;
      if (image_fill < MaxPoints) begin
        for (i = 0; i < image_fill; i++) begin
          if (kept_x[i] == p.x_pos && kept_y[i] == p.y_pos) begin
            dup = 1'b1;
          end
        end
        want.point_index = PointIdxW'(image_fill);
        want.keep        = !dup;
        kept_x[image_fill] = p.x_pos;
        kept_y[image_fill] = p.y_pos;
        image_fill++;
      end else begin
        // store full: point dropped, index pinned to the last slot
        want.overflow    = 1'b1;
        want.point_index = PointIdxW'(MaxPoints - 1);
      end
      want.image_end = p.last_point;
      if (p.last_point) begin
        image_fill = 0;
      end
      expected_q = {expected_q, want};
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted output beat.
    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no point pending: index %0d", got.point_index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("point_index", want.point_index, got.point_index);
      compare_field("keep", want.keep, got.keep);
      compare_field("image_end", want.image_end, got.image_end);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ tb/sv/duplicate_point_filter_tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench for duplicate_point_filter: directed and random images,
// random idling on both channels. Depends on dpf_pkg and dpf_tb_pkg.

module duplicate_point_filter_tb;
  import dpf_pkg::*;
  import dpf_tb_pkg::*;

  localparam int unsigned CoordMax     = (1 << CoordBits) - 1;
  localparam int          StallMax     = 13;
  localparam int          IdleLimit    = 2000;
  localparam int          TailCycles   = 300;
  localparam int          RandomPoints = 1300;
  localparam int          QuietPoints  = 150;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  dedup_scoreboard dedup_sb;
  int unsigned     points_sent = 0;
  bit              quiet = 1'b0;
  in_t             img_pts [$];
  in_t             prev_pts [$];

  duplicate_point_filter uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // beat monitor: both channels sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        dedup_sb.note_point(in_data);
      end
      if (out_valid && out_ready) begin
        dedup_sb.check_result(out_data);
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, StallMax)) @(posedge clk);
      end
      out_ready <= 1'b1;
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 24);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_t point_at(int unsigned x, int unsigned y, bit last);
    in_t p;
    p.x_pos      = CoordBits'(x);
    p.y_pos      = CoordBits'(y);
    p.last_point = last;
    return p;
  endfunction

  function automatic in_t pick_point();
    in_t         p;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    p.x_pos      = CoordBits'($urandom());
    p.y_pos      = CoordBits'($urandom());
    p.last_point = 1'b0;
    case (sel)
      3: begin
        p.x_pos = CoordBits'($urandom_range(0, 3));
        p.y_pos = CoordBits'($urandom_range(0, 3));
      end
      4: begin
        p.x_pos = $urandom_range(0, 1) ? CoordBits'(CoordMax) : '0;
        p.y_pos = $urandom_range(0, 1) ? CoordBits'(CoordMax) : '0;
      end
      5, 6: begin
        if (img_pts.size() != 0) p = img_pts[$urandom_range(0, img_pts.size() - 1)];
      end
      7: begin
        // differs from an earlier point in one bit only
        if (img_pts.size() != 0) begin
          p = img_pts[$urandom_range(0, img_pts.size() - 1)];
          if ($urandom_range(0, 1)) begin
            p.x_pos ^= CoordBits'(1) << $urandom_range(0, CoordBits - 1);
          end else begin
            p.y_pos ^= CoordBits'(1) << $urandom_range(0, CoordBits - 1);
          end
        end
      end
      8: begin
        if (prev_pts.size() != 0) p = prev_pts[$urandom_range(0, prev_pts.size() - 1)];
      end
      9: begin
        p.x_pos = CoordBits'(CoordMax - $urandom_range(0, 3));
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic send_point(in_t p, bit gappy);
    if (gappy && !quiet && $urandom_range(0, 2) == 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dedup_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_image(int unsigned n, bit gappy);
    in_t         p;
    int unsigned k;
    img_pts.delete();
    for (k = 0; k < n; k++) begin
      p = pick_point();
      p.last_point = (k == n - 1);
      send_point(p, gappy);
      img_pts = {img_pts, p};
    end
    prev_pts = img_pts;
  endtask

  task automatic run_directed();
    send_point(point_at(0, 0, 1'b0), 1'b0);
    send_point(point_at(CoordMax, CoordMax, 1'b0), 1'b0);
    send_point(point_at(0, 0, 1'b0), 1'b1);
    send_point(point_at(CoordMax, 0, 1'b0), 1'b0);
    send_point(point_at(0, CoordMax, 1'b0), 1'b1);
    send_point(point_at(CoordMax, CoordMax, 1'b0), 1'b0);
    send_point(point_at(0, 0, 1'b0), 1'b0);
    send_point(point_at(1, 0, 1'b0), 1'b1);
    send_point(point_at(0, 1, 1'b0), 1'b0);
    send_point(point_at('h200000, 'h155555, 1'b0), 1'b0);
    send_point(point_at('h155555, 'h200000, 1'b0), 1'b1);
    // duplicate that also closes the image
    send_point(point_at('h200000, 'h155555, 1'b1), 1'b0);
    // same coordinates start a fresh image and are kept again
    send_point(point_at('h200000, 'h155555, 1'b1), 1'b0);
    send_point(point_at(0, 0, 1'b1), 1'b1);
    send_point(point_at('h2AAAAA, 'h155555, 1'b0), 1'b0);
    send_point(point_at('h2AAAAA, 'h155555, 1'b1), 1'b0);
  endtask

  initial begin
    int unsigned n;
    dedup_sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_drained();
    // fill the store, then two points past capacity, the last one ending it
    run_image(MaxPoints + 2, 1'b1);
    run_image(MaxPoints, 1'b0);
    wait_drained();
    while (points_sent < RandomPoints) begin
      quiet = (points_sent >= RandomPoints - QuietPoints);
      n = ($urandom_range(0, 99) == 0) ? $urandom_range(MaxPoints - 6, MaxPoints + 6)
                                        : $urandom_range(1, 24);
      run_image(n, $urandom_range(0, 1));
      if (!quiet && $urandom_range(0, 15) == 0) wait_drained();
    end
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (dedup_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dpf_pkg.sv
rtl/dpf_store.sv
rtl/dpf_ctrl.sv
rtl/duplicate_point_filter.sv
rtl/dpf_checker.sv
tb/sv/dpf_tb_pkg.sv
tb/sv/duplicate_point_filter_tb.sv
